[rtl/core/tiny_mlp_lms_output_trainer_defines.svh]
// assertion macros shared by the rtl
`ifndef TINY_MLP_LMS_OUTPUT_TRAINER_DEFINES_SVH
`define TINY_MLP_LMS_OUTPUT_TRAINER_DEFINES_SVH
// plain implication checked on every clock while out of reset
`define TM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define TM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[rtl/core/tmlp_pkg.sv]
package tmlp_pkg;
	localparam int NUM_WEIGHTS = 33;
	localparam int WIDX_W = 6;
	localparam int DEF_OPTION_LIMIT = 16;
	localparam int DEF_FRACTION_BITS = 16;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TRAIN = 2'd1,
		CMD_ASSESS = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] weight_index;
		logic signed [31:0] weight_value;
		logic signed [31:0] cue;
		logic signed [31:0] target;
		logic signed [31:0] quality;
		logic last_option;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] network_out;
		logic [3:0] chosen_option;
		logic decision_done;
		logic signed [47:0] fitness_total;
		logic signed [47:0] best_total;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

[rtl/core/tmlp_ram.sv]
module tmlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 33
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/tiny_mlp_lms_output_trainer.sv]
// channel | direction | handshake        | payload
// in      | input     | in_valid/ready   | tmlp_pkg::in_item_t
// out     | output    | out_valid/ready  | tmlp_pkg::out_item_t
// cfg     | input     | cfg_valid/ready  | learn_rate[19:0]
// evaluate runs 24 products through one shared 32x34 multiplier, read, wait, multiply,
// accumulate each, plus a bias read and wait at the head of every sum
// assess adds a score step, train adds per output weight a read, wait, 2 mults and write
// reset clears control, scores and learn rate; weights stay undefined until loaded
// in_ready is low while an item is at work or its result waits on a stalled out
module tiny_mlp_lms_output_trainer #(
	parameter int OPTION_LIMIT = tmlp_pkg::DEF_OPTION_LIMIT,
	parameter int FRACTION_BITS = tmlp_pkg::DEF_FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tmlp_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output tmlp_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [19:0] cfg_data
);
	import tmlp_pkg::*;
	`include "tiny_mlp_lms_output_trainer_defines.svh"

	localparam int CNT_W = $clog2(OPTION_LIMIT + 1);
	localparam logic signed [33:0] ONE = 34'sd1 <<< FRACTION_BITS;

	// sequencer phases
	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_WAIT, S_MUL, S_ACC, S_UPD_RD, S_UPD_WAIT, S_UPD_M1,
		S_UPD_M2, S_UPD_WR, S_SCORE, S_OUT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [19:0] rate_q;
	logic [4:0] step_q;     // product index in the evaluate schedule
	logic [1:0] upd_q;      // output weight being trained
	logic signed [33:0] h_q [4];
	logic signed [33:0] g_q [4];
	logic signed [65:0] acc_q;
	logic signed [31:0] wrd_q;
	logic signed [31:0] y_q, err_q;
	logic signed [31:0] best_score_q, chosen_q_q, max_q_q;
	logic [7:0] best_index_q;
	logic [CNT_W-1:0] count_q;
	logic signed [47:0] fit_q, bsum_q;
	logic done_q;

	// ram
	logic ram_we;
	logic [5:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	tmlp_ram #(.WIDTH(32), .DEPTH(NUM_WEIGHTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// schedule: steps 0..3 hidden (bias then slope), 4..19 second layer,
	// 20..23 output; a bias address is read first in a group, then products
	// step s: hidden i=s: weight 9+i * x, bias i
	// step 4+4j+i: weight 13+j+4i * h[i], bias 4+j at i=0
	// step 20+j: weight 29+j * g[j], bias 8 at j=0
	logic [5:0] waddr_c, baddr_c;
	logic signed [33:0] mop_c;
	logic close_c;
	logic [1:0] jj, ii;
	always_comb begin
		jj = step_q[3:2];
		ii = step_q[1:0];
		waddr_c = '0; baddr_c = '0; mop_c = '0; close_c = 1'b0;
		if (step_q < 5'd4) begin
			waddr_c = 6'd9 + {4'd0, step_q[1:0]};
			baddr_c = {4'd0, step_q[1:0]};
			mop_c = {{2{item_q.cue[31]}}, item_q.cue};
			close_c = 1'b1;
		end else if (step_q < 5'd20) begin
			jj = 2'(({1'b0, step_q} - 6'd4) >> 2);
			ii = 2'({1'b0, step_q} - 6'd4);
			waddr_c = 6'd13 + {4'd0, jj} + {2'd0, ii, 2'd0};
			baddr_c = 6'd4 + {4'd0, jj};
			mop_c = h_q[ii];
			close_c = (ii == 2'd3);
		end else begin
			jj = 2'(step_q - 5'd20);
			waddr_c = 6'd29 + {4'd0, jj};
			baddr_c = 6'd8;
			mop_c = g_q[jj];
			close_c = (jj == 2'd3);
		end
	end

	// shared multiplier, one product per use, registered
	logic signed [31:0] ma;
	logic signed [33:0] mb;
	logic signed [65:0] prod_c;
	logic signed [65:0] prod_q;
	logic bias_phase_q;
	logic signed [65:0] fshift;
	assign fshift = prod_q >>> FRACTION_BITS;
	assign prod_c = ma * mb;
	always_comb begin
		ma = wrd_q; mb = mop_c;
		if (state_q == S_UPD_M1) begin ma = err_q; mb = g_q[upd_q]; end
		// err*g scaled down feeds straight back in, times the rate
		if (state_q == S_UPD_M2) begin
			ma = fshift[31:0]; mb = {14'd0, rate_q};
		end
	end

	function automatic logic signed [33:0] clamp01(input logic signed [65:0] v);
		if (v < 0) return '0;
		if (v > 66'(ONE)) return ONE;
		return v[33:0];
	endfunction

	logic signed [47:0] fit_add, bs_add;
	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v > 49'sh7fffffffffff) return 48'sh7fffffffffff;
		if (v < -49'sh800000000000) return 48'sh800000000000;
		return v[47:0];
	endfunction
	assign fit_add = sat48(49'(fit_q) + 49'(chosen_q_q));
	assign bs_add = sat48(49'(bsum_q) + 49'(max_q_q));

	logic signed [31:0] wnew_c;
	assign wnew_c = sat32(66'(wrd_q) + fshift);

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		ram_we = 1'b0; ram_waddr = item_q.weight_index; ram_wdata = item_q.weight_value;
		ram_raddr = bias_phase_q ? baddr_c : waddr_c;
		if (in_valid && in_ready && in_data.command == CMD_LOAD &&
				in_data.weight_index < 6'(NUM_WEIGHTS)) begin
			ram_we = 1'b1; ram_waddr = in_data.weight_index; ram_wdata = in_data.weight_value;
		end
		if (state_q == S_UPD_RD || state_q == S_UPD_WAIT || state_q == S_UPD_M1 ||
				state_q == S_UPD_M2 || state_q == S_UPD_WR)
			ram_raddr = 6'd29 + {4'd0, upd_q};
		if (state_q == S_UPD_WR) begin
			ram_we = 1'b1; ram_waddr = 6'd29 + {4'd0, upd_q}; ram_wdata = wnew_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			rate_q <= '0;
			best_score_q <= '0; chosen_q_q <= '0; max_q_q <= '0;
			best_index_q <= '0; count_q <= '0; fit_q <= '0; bsum_q <= '0;
			done_q <= 1'b0; step_q <= '0; upd_q <= '0; bias_phase_q <= 1'b0;
			y_q <= '0; err_q <= '0; wrd_q <= '0; acc_q <= '0; prod_q <= '0;
			h_q <= '{default: '0}; g_q <= '{default: '0};
		end else begin
			if (cfg_valid) rate_q <= cfg_data;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					item_q <= in_data;
					done_q <= 1'b0; y_q <= '0;
					step_q <= '0; upd_q <= '0;
					unique case (cmd_t'(in_data.command))
						CMD_LOAD: state_q <= S_OUT;
						CMD_CLEAR: begin
							fit_q <= '0; bsum_q <= '0; count_q <= '0;
							best_score_q <= '0; chosen_q_q <= '0; max_q_q <= '0;
							best_index_q <= '0;
							state_q <= S_OUT;
						end
						default: begin bias_phase_q <= 1'b1; state_q <= S_RD; end
					endcase
				end
				S_RD: state_q <= S_WAIT;
				S_WAIT: begin
					if (bias_phase_q) begin
						acc_q <= 66'(signed'(ram_rdata));
						bias_phase_q <= 1'b0;
						state_q <= S_RD;
					end else begin
						wrd_q <= ram_rdata;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin prod_q <= prod_c; state_q <= S_ACC; end
				S_ACC: begin
					if (close_c) begin
						if (step_q < 5'd4) h_q[step_q[1:0]] <= clamp01(acc_q + fshift);
						else if (step_q < 5'd20) g_q[jj] <= clamp01(acc_q + fshift);
						else y_q <= sat32(acc_q + fshift);
					end else acc_q <= acc_q + fshift;
					if (step_q == 5'd23) begin
						state_q <= (item_q.command == CMD_TRAIN) ? S_UPD_RD : S_SCORE;
						if (item_q.command == CMD_TRAIN)
							err_q <= sat32(66'(item_q.target) - 66'(sat32(acc_q + fshift)));
					end else begin
						step_q <= step_q + 5'd1;
						bias_phase_q <= close_c;
						state_q <= S_RD;
					end
				end
				S_UPD_RD: state_q <= S_UPD_WAIT;
				S_UPD_WAIT: begin wrd_q <= ram_rdata; state_q <= S_UPD_M1; end
				S_UPD_M1: begin prod_q <= prod_c; state_q <= S_UPD_M2; end
				// eg*rate into prod_q, WR writes the saturated sum
				S_UPD_M2: begin prod_q <= prod_c; state_q <= S_UPD_WR; end
				S_UPD_WR: begin
					state_q <= (upd_q == 2'd3) ? S_OUT : S_UPD_RD;
					upd_q <= upd_q + 2'd1;
				end
				S_SCORE: begin
					state_q <= S_OUT;
					if (item_q.last_option) done_q <= 1'b1;
					if (count_q == '0) begin
						best_score_q <= y_q; best_index_q <= '0;
						chosen_q_q <= item_q.quality; max_q_q <= item_q.quality;
						count_q <= CNT_W'(1);
					end else if (count_q < CNT_W'(OPTION_LIMIT)) begin
						if (y_q > best_score_q) begin
							best_score_q <= y_q; best_index_q <= 8'(count_q);
							chosen_q_q <= item_q.quality;
						end
						if (item_q.quality > max_q_q) max_q_q <= item_q.quality;
						count_q <= count_q + CNT_W'(1);
					end
				end
				// totals are shown including the closing group; committed on handoff
				S_OUT: if (out_ready) begin
					state_q <= S_IDLE;
					if (done_q) begin
						fit_q <= fit_add; bsum_q <= bs_add;
						count_q <= '0; best_score_q <= '0; chosen_q_q <= '0; max_q_q <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		out_data.network_out = y_q;
		out_data.chosen_option = best_index_q[3:0];
		out_data.decision_done = done_q;
		out_data.fitness_total = done_q ? fit_add : fit_q;
		out_data.best_total = done_q ? bs_add : bsum_q;
	end

	`TM_ASSERT_IMP(a_rdy_idle, clk, arst_n, in_ready, !out_valid)
	`TM_ASSERT_NXT(a_acc_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`TM_ASSERT_IMP(a_cnt_lim, clk, arst_n, 1'b1, count_q <= CNT_W'(OPTION_LIMIT))
endmodule
